[sv/dso_pkg.sv]
package dso_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_EDGE_THRESHOLD = 3'd2,
        REG_OUTLINE_RED    = 3'd3,
        REG_OUTLINE_GREEN  = 3'd4,
        REG_OUTLINE_BLUE   = 3'd5
    } cfg_index_t;

    localparam int COLOR_BITS = 24;
    localparam int CFG_BITS   = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SIZE_BITS  = 12;
    localparam int COORD_BITS = 11;
    localparam int IN_DEPTH_BITS = 24;
    localparam int MIN_SIZE   = 3;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 12'd480;

    // Line-buffer write and read control.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ls_ctrl_t;

endpackage

[sv/dso_line_store.sv]
module dso_line_store #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 98,
    parameter int ENTRIES   = 2048
) (
    input  logic                 clk,
    input  dso_pkg::ls_ctrl_t    ctrl,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [ENTRIES];
    logic [DATA_BITS-1:0] rd_data_reg;

    // One write port and one registered read port; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/depth_sobel_outline_core.sv]
// Depth outline filter. Pixels come in raster order, one item per clock, and
// the core forms a 3x3 window from two line buffers held in one shared RAM. A
// Sobel gradient on the depths (background counts as depth 0) is compared
// per axis against the threshold and as a sum of squares against the
// squared threshold, and a pixel next to background is also an edge; a
// background center never is. One result comes out per interior pixel,
// one row and one column after that pixel went in, carrying its
// coordinates. Throughput is one item per clock; a result passes through
// five register stages (RAM read, window, gradient, square, compare), the
// first of which is loaded at the accepting edge. The whole pipeline advances
// together, so a stall on the output holds the input. Width and height are
// clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; write configuration only while
// the core is idle.
module depth_sobel_outline_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int DEPTH_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // depth_value[23:0], pixel_red[31:24], pixel_green[39:32], pixel_blue[47:40]
    input  logic [47:0] s_axis_tdata,
    // is_background[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_red[7:0], result_green[15:8], result_blue[23:16], center_x[34:24],
    // center_y[45:35], zero fill[47:46]
    output logic [47:0] m_axis_tdata,
    // edge_found[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DW    = (DEPTH_BITS < dso_pkg::IN_DEPTH_BITS) ? DEPTH_BITS
                                                                 : dso_pkg::IN_DEPTH_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WB    = CW + 1;
    localparam int HB    = RW + 1;
    localparam int CELLW = DW + 1 + dso_pkg::COLOR_BITS;
    localparam int MEMW  = 2 * CELLW;
    localparam int GW    = DW + 2;
    localparam int SQW   = 2 * GW;
    localparam int TSQW  = 2 * dso_pkg::CFG_BITS;
    localparam int CMPW  = (SQW + 1 > TSQW) ? SQW + 1 : TSQW;
    localparam int XW    = dso_pkg::COORD_BITS;
    localparam int CB    = dso_pkg::COLOR_BITS;

    // Configuration registers.
    logic [dso_pkg::SIZE_BITS-1:0] width_reg, height_reg;
    logic [23:0] threshold_reg;
    logic [7:0]  outline_r_reg, outline_g_reg, outline_b_reg;
    logic [TSQW-1:0] tsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= dso_pkg::WIDTH_RESET;
            height_reg    <= dso_pkg::HEIGHT_RESET;
            threshold_reg <= '0;
            outline_r_reg <= '0;
            outline_g_reg <= '0;
            outline_b_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (dso_pkg::cfg_index_t'(cfg_index))
                dso_pkg::REG_IMAGE_WIDTH:    width_reg     <= cfg_wr_data[11:0];
                dso_pkg::REG_IMAGE_HEIGHT:   height_reg    <= cfg_wr_data[11:0];
                dso_pkg::REG_EDGE_THRESHOLD: threshold_reg <= cfg_wr_data;
                dso_pkg::REG_OUTLINE_RED:    outline_r_reg <= cfg_wr_data[7:0];
                dso_pkg::REG_OUTLINE_GREEN:  outline_g_reg <= cfg_wr_data[7:0];
                dso_pkg::REG_OUTLINE_BLUE:   outline_b_reg <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // The squared threshold only changes with configuration.
    always_ff @(posedge clk)
    begin
        tsq_reg <= TSQW'(threshold_reg) * TSQW'(threshold_reg);
    end

    // Effective frame size after clamping.
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;

    always_comb
    begin
        if (32'(width_reg) < 32'(dso_pkg::MIN_SIZE))
            w_eff = WB'(dso_pkg::MIN_SIZE);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        if (32'(height_reg) < 32'(dso_pkg::MIN_SIZE))
            h_eff = HB'(dso_pkg::MIN_SIZE);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(height_reg);
    end

    // The whole pipeline moves when the output register is free or being taken.
    logic adv, accept;
    assign adv    = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept = s_axis_tvalid && adv;

    // Raster position counters.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          in_res;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (WB'(col_reg) + WB'(1) >= w_eff)
        begin
            col_next = '0;
            if (HB'(row_reg) + HB'(1) >= h_eff)
                row_next = '0;
            else
                row_next = row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
        in_res = (WB'(col_reg) >= WB'(2)) && (HB'(row_reg) >= HB'(2))
              && (WB'(col_reg) < w_eff) && (HB'(row_reg) < h_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: incoming pixel waits for the line-buffer read.
    logic              s1_valid_reg, s1_res_reg;
    logic [DW-1:0]     s1_depth_reg;
    logic              s1_bg_reg;
    logic [CB-1:0]     s1_color_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic [XW-1:0]     s1_cx_reg, s1_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg   <= in_res;
            s1_depth_reg <= s_axis_tdata[DW-1:0];
            s1_bg_reg    <= s_axis_tuser[0];
            s1_color_reg <= {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40]};
            s1_addr_reg  <= col_reg;
            s1_cx_reg    <= XW'(col_reg - CW'(1));
            s1_cy_reg    <= XW'(row_reg - RW'(1));
        end
    end

    // Line buffers: upper cell in the high half, middle cell in the low half.
    dso_pkg::ls_ctrl_t ls_ctrl;
    logic [MEMW-1:0]   ls_rd_data;
    logic [CELLW-1:0]  up_cell, mid_cell, px_cell;

    assign ls_ctrl.rd_en = accept;
    assign ls_ctrl.wr_en = s1_valid_reg && adv;
    assign up_cell  = ls_rd_data[MEMW-1:CELLW];
    assign mid_cell = ls_rd_data[CELLW-1:0];
    assign px_cell  = {s1_depth_reg, s1_bg_reg, s1_color_reg};

    dso_line_store #(
        .ADDR_BITS (CW),
        .DATA_BITS (MEMW),
        .ENTRIES   (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .ctrl    (ls_ctrl),
        .rd_addr (col_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({mid_cell, px_cell}),
        .rd_data (ls_rd_data)
    );

    // Window of effective depths and flags, shifted once per item.
    logic [DW-1:0] win_d_reg [3][3];
    logic          win_b_reg [3][3];
    logic [CB-1:0] center_color_reg, newest_mid_reg;
    logic [DW-1:0] col_d [3];
    logic          col_b [3];

    always_comb
    begin
        col_b[0] = up_cell[CB];
        col_b[1] = mid_cell[CB];
        col_b[2] = s1_bg_reg;
        col_d[0] = col_b[0] ? '0 : up_cell[CELLW-1:CB+1];
        col_d[1] = col_b[1] ? '0 : mid_cell[CELLW-1:CB+1];
        col_d[2] = col_b[2] ? '0 : s1_depth_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_d_reg[i][j] <= '0;
                    win_b_reg[i][j] <= 1'b0;
                end
            end
            center_color_reg <= '0;
            newest_mid_reg   <= '0;
        end
        else if (s1_valid_reg && adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_d_reg[i][0] <= win_d_reg[i][1];
                win_b_reg[i][0] <= win_b_reg[i][1];
                win_d_reg[i][1] <= win_d_reg[i][2];
                win_b_reg[i][1] <= win_b_reg[i][2];
                win_d_reg[i][2] <= col_d[i];
                win_b_reg[i][2] <= col_b[i];
            end
            center_color_reg <= newest_mid_reg;
            newest_mid_reg   <= mid_cell[CB-1:0];
        end
    end

    // Stage 2: item sits with its window in place.
    logic          s2_valid_reg;
    logic [XW-1:0] s2_cx_reg, s2_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cx_reg  <= s1_cx_reg;
            s2_cy_reg  <= s1_cy_reg;
        end
    end

    // Sobel sums and absolute gradients.
    logic [GW-1:0] gx_pos, gx_neg, gy_pos, gy_neg, ax, ay;
    logic          nb_bg;

    always_comb
    begin
        gx_pos = GW'(win_d_reg[0][2]) + (GW'(win_d_reg[1][2]) << 1) + GW'(win_d_reg[2][2]);
        gx_neg = GW'(win_d_reg[0][0]) + (GW'(win_d_reg[1][0]) << 1) + GW'(win_d_reg[2][0]);
        gy_pos = GW'(win_d_reg[2][0]) + (GW'(win_d_reg[2][1]) << 1) + GW'(win_d_reg[2][2]);
        gy_neg = GW'(win_d_reg[0][0]) + (GW'(win_d_reg[0][1]) << 1) + GW'(win_d_reg[0][2]);
        ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        nb_bg = win_b_reg[0][0] || win_b_reg[0][1] || win_b_reg[0][2]
             || win_b_reg[1][0] || win_b_reg[1][2]
             || win_b_reg[2][0] || win_b_reg[2][1] || win_b_reg[2][2];
    end

    // Stage 3: gradients registered.
    logic          s3_valid_reg, s3_nb_reg, s3_cbg_reg;
    logic [GW-1:0] s3_ax_reg, s3_ay_reg;
    logic [CB-1:0] s3_color_reg;
    logic [XW-1:0] s3_cx_reg, s3_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ax_reg    <= ax;
            s3_ay_reg    <= ay;
            s3_nb_reg    <= nb_bg;
            s3_cbg_reg   <= win_b_reg[1][1];
            s3_color_reg <= center_color_reg;
            s3_cx_reg    <= s2_cx_reg;
            s3_cy_reg    <= s2_cy_reg;
        end
    end

    // Stage 4: squares and the plain threshold compare.
    logic           s4_valid_reg, s4_nb_reg, s4_cbg_reg, s4_gt_reg;
    logic [SQW-1:0] s4_sqx_reg, s4_sqy_reg;
    logic [CB-1:0]  s4_color_reg;
    logic [XW-1:0]  s4_cx_reg, s4_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sqx_reg   <= SQW'(s3_ax_reg) * SQW'(s3_ax_reg);
            s4_sqy_reg   <= SQW'(s3_ay_reg) * SQW'(s3_ay_reg);
            s4_gt_reg    <= (CMPW'(s3_ax_reg) > CMPW'(threshold_reg))
                         || (CMPW'(s3_ay_reg) > CMPW'(threshold_reg));
            s4_nb_reg    <= s3_nb_reg;
            s4_cbg_reg   <= s3_cbg_reg;
            s4_color_reg <= s3_color_reg;
            s4_cx_reg    <= s3_cx_reg;
            s4_cy_reg    <= s3_cy_reg;
        end
    end

    // Edge decision and color choice.
    logic          edge_hit;
    logic [CB-1:0] out_color;

    always_comb
    begin
        edge_hit = !s4_cbg_reg
                && (s4_gt_reg || s4_nb_reg
                    || (CMPW'(s4_sqx_reg) + CMPW'(s4_sqy_reg) > CMPW'(tsq_reg)));
        out_color = edge_hit ? {outline_r_reg, outline_g_reg, outline_b_reg} : s4_color_reg;
    end

    // Output register.
    logic          out_valid_reg, out_edge_reg;
    logic [CB-1:0] out_color_reg;
    logic [XW-1:0] out_cx_reg, out_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_edge_reg  <= edge_hit;
            out_color_reg <= out_color;
            out_cx_reg    <= s4_cx_reg;
            out_cy_reg    <= s4_cy_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_edge_reg;
    assign m_axis_tdata  = {2'b00, out_cy_reg, out_cx_reg, out_color_reg[7:0],
                            out_color_reg[15:8], out_color_reg[23:16]};

    // Results only describe interior pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_cx_reg != '0) && (out_cy_reg != '0))
        else $error("result for a border pixel");

    // An item leaving the last stage lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && adv) |=> m_axis_tvalid)
        else $error("item lost between compare stage and output");

    // An empty output register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A background center is never reported as an edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_cbg_reg && adv) |=> !out_edge_reg)
        else $error("background center marked as edge");

endmodule
